FILE: hdl/pvc_pkg.sv
// ----------------------------------------------------------------------------
// pvc_pkg
// Shared widths, register codes, types and helpers for the plane velocity
// constraint pipeline.
// ----------------------------------------------------------------------------
package pvc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GAIN_W = 20;
  localparam int STEP_W = 16;
  localparam int ADDR_W = 4;

  // Magnitude of gain times a saturated 32-bit constraint error.
  localparam int PROD_MAG_W = GAIN_W + 31;
  localparam int BIAS_LAT = PROD_MAG_W + 1;

  // Velocity change quotient: capped at 2^32, so 33 bits.
  localparam int QUO_W = 33;
  localparam int OVR_SHIFT = QUO_W - FRAC_BITS;
  localparam int IMP_LAT = QUO_W + 3;

  localparam int PIPE_LAT = 3 + BIAS_LAT + 1 + IMP_LAT;

  localparam logic [1:0] REG_GAIN = 2'd0;
  localparam logic [1:0] REG_MIN_STEP = 2'd1;
  localparam logic [1:0] REG_FALLBACK = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd66191;
  localparam logic [STEP_W-1:0] MIN_STEP_RESET = 16'd1;
  localparam logic [STEP_W-1:0] FALLBACK_RESET = 16'd1092;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    vec3_t       vel;
    vec3_t       nrm;
    logic [63:0] nn;
    logic [31:0] jv;
    logic        degenerate;
  } side_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'h7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'h80000000;
    end else begin
      return x[31:0];
    end
  endfunction

endpackage

FILE: hdl/plane_velocity_constraint_top.sv
// ----------------------------------------------------------------------------
// plane_velocity_constraint_top
// Pipeline: three product and sum stages, 52 bias divider stages, one merge,
// 36 impulse lane stages, then one output buffer write. Throughput: one
// transaction per cycle unless the output buffer is full and not draining, set
// by the fully pipelined dividers in the bias unit and the three axis lanes.
// Reset: synchronous rst clears pipeline valids, the output buffer and
// loads the default gain, minimum step and fallback step.
// ----------------------------------------------------------------------------
module plane_velocity_constraint_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pvc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [31:0]         pos_x,
  input  logic signed [31:0]         pos_y,
  input  logic signed [31:0]         pos_z,
  input  logic signed [31:0]         vel_x,
  input  logic signed [31:0]         vel_y,
  input  logic signed [31:0]         vel_z,
  input  logic signed [31:0]         normal_x,
  input  logic signed [31:0]         normal_y,
  input  logic signed [31:0]         normal_z,
  input  logic signed [31:0]         plane_offset,
  input  logic [31:0]                body_mass,
  input  logic [15:0]                delta_time,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         new_vel_x,
  output logic signed [31:0]         new_vel_y,
  output logic signed [31:0]         new_vel_z,
  output logic                       degenerate
);
  import pvc_pkg::*;

  typedef struct packed {
    vec3_t vel;
    logic  degenerate;
  } result_t;

  localparam int LAST = PIPE_LAT - 1;
  localparam logic [1:0] FIFO_FULL = 2'd2;

  logic [GAIN_W-1:0] gain;
  logic [STEP_W-1:0] min_step, fallback_step;

  logic en;
  logic [PIPE_LAT-1:0] vld;

  vec3_t pos_v, vel_v, nrm_v;
  logic [STEP_W-1:0] dt_sel, dt_eff;

  // Stage A
  logic signed [63:0] pn_a [3];
  logic signed [63:0] vn_a [3];
  logic [63:0]        nsq_a [3];
  vec3_t              vel_a, nrm_a;
  logic signed [31:0] d_a;
  logic               degen_a;
  logic [STEP_W-1:0]  dt_a;

  // Stage B
  logic signed [63:0] d_ext, c_wide, jv_wide;
  logic signed [31:0] c_b;
  logic [STEP_W-1:0]  dt_b;
  side_t              side_b;

  // Stage C
  logic signed [52:0]    gprod;
  logic [PROD_MAG_W-1:0] mag_c;
  logic                  neg_c;
  logic [STEP_W-1:0]     dt_c;
  side_t                 side_c;

  // Bias output and stage S
  logic signed [31:0] bias_d;
  side_t              side_d;
  logic signed [33:0] jv_ext, bias_ext, s_w;
  logic [QUO_W-1:0]   smag_s;
  logic               sneg_s;
  side_t              side_s;

  vec3_t   vel_out;
  logic    degen_out;

  result_t fifo_mem [2];
  logic    wptr, rptr;
  logic [1:0] count;
  logic    push, pop;
  result_t head;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain          <= GAIN_RESET;
      min_step      <= MIN_STEP_RESET;
      fallback_step <= FALLBACK_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_GAIN:     gain          <= pwdata[GAIN_W-1:0];
        REG_MIN_STEP: min_step      <= pwdata[STEP_W-1:0];
        REG_FALLBACK: fallback_step <= pwdata[STEP_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GAIN:     prdata = 32'(gain);
      REG_MIN_STEP: prdata = 32'(min_step);
      REG_FALLBACK: prdata = 32'(fallback_step);
      default:      prdata = 32'd0;
    endcase
  end

  // The pipeline only halts when the buffer is full and cannot drain.
  assign en       = !vld[LAST] || (count != FIFO_FULL) || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  assign pos_v = {pos_z, pos_y, pos_x};
  assign vel_v = {vel_z, vel_y, vel_x};
  assign nrm_v = {normal_z, normal_y, normal_x};

  assign dt_sel = (delta_time < min_step || delta_time == '0) ? fallback_step : delta_time;
  assign dt_eff = (dt_sel == '0) ? STEP_W'(1) : dt_sel;

  for (genvar i = 0; i < 3; i++) begin : g_dot
    pvc_lane_dot u_dot (
      .clk (clk),
      .en  (en),
      .pos ($signed(pos_v[i])),
      .vel ($signed(vel_v[i])),
      .nrm ($signed(nrm_v[i])),
      .pn  (pn_a[i]),
      .vn  (vn_a[i]),
      .nsq (nsq_a[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vel_a   <= vel_v;
      nrm_a   <= nrm_v;
      d_a     <= plane_offset;
      degen_a <= (body_mass == '0) ||
                 (normal_x == '0 && normal_y == '0 && normal_z == '0);
      dt_a    <= dt_eff;
    end
  end

  // Products are floored to the fixed-point scale before summing.
  assign d_ext   = d_a;
  assign c_wide  = (pn_a[0] >>> FRAC_BITS) + (pn_a[1] >>> FRAC_BITS) +
                   (pn_a[2] >>> FRAC_BITS) - d_ext;
  assign jv_wide = (vn_a[0] >>> FRAC_BITS) + (vn_a[1] >>> FRAC_BITS) +
                   (vn_a[2] >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      c_b               <= sat32(c_wide);
      side_b.jv         <= sat32(jv_wide);
      side_b.nn         <= nsq_a[0] + nsq_a[1] + nsq_a[2];
      side_b.vel        <= vel_a;
      side_b.nrm        <= nrm_a;
      side_b.degenerate <= degen_a;
      dt_b              <= dt_a;
    end
  end

  assign gprod = $signed({1'b0, gain}) * c_b;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_c  <= gprod[52] ? PROD_MAG_W'(-gprod) : PROD_MAG_W'(gprod);
      neg_c  <= gprod[52];
      dt_c   <= dt_b;
      side_c <= side_b;
    end
  end

  pvc_bias_div u_bias (
    .clk      (clk),
    .en       (en),
    .mag      (mag_c),
    .neg      (neg_c),
    .dt       (dt_c),
    .side_in  (side_c),
    .bias     (bias_d),
    .side_out (side_d)
  );

  assign jv_ext   = $signed(side_d.jv);
  assign bias_ext = bias_d;
  assign s_w      = -jv_ext - bias_ext;

  always_ff @(posedge clk) begin
    if (en) begin
      sneg_s <= s_w[33];
      smag_s <= s_w[33] ? QUO_W'(-s_w) : QUO_W'(s_w);
      side_s <= side_d;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_imp
    if (i == 0) begin : g_flag
      pvc_impulse_lane u_imp (
        .clk       (clk),
        .en        (en),
        .nrm       (side_s.nrm[i]),
        .smag      (smag_s),
        .s_neg     (sneg_s),
        .nn        (side_s.nn),
        .vel       (side_s.vel[i]),
        .degen_in  (side_s.degenerate),
        .new_vel   (vel_out[i]),
        .degen_out (degen_out)
      );
    end else begin : g_plain
      pvc_impulse_lane u_imp (
        .clk       (clk),
        .en        (en),
        .nrm       (side_s.nrm[i]),
        .smag      (smag_s),
        .s_neg     (sneg_s),
        .nn        (side_s.nn),
        .vel       (side_s.vel[i]),
        .degen_in  (side_s.degenerate),
        .new_vel   (vel_out[i]),
        .degen_out ()
      );
    end
  end

  // Two-entry output buffer decouples the result side from the pipeline.
  assign push = en && vld[LAST];
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wptr] <= '{vel: vel_out, degenerate: degen_out};
    end
  end

  assign head       = fifo_mem[rptr];
  assign out_valid  = count != 2'd0;
  assign new_vel_x  = head.vel[0];
  assign new_vel_y  = head.vel[1];
  assign new_vel_z  = head.vel[2];
  assign degenerate = head.degenerate;

endmodule

FILE: hdl/pvc_lane_dot.sv
// ----------------------------------------------------------------------------
// pvc_lane_dot
// One axis of the input products: n*p, n*v and n*n, registered.
// ----------------------------------------------------------------------------
module pvc_lane_dot (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] pos,
  input  logic signed [31:0] vel,
  input  logic signed [31:0] nrm,
  output logic signed [63:0] pn,
  output logic signed [63:0] vn,
  output logic        [63:0] nsq
);

  always_ff @(posedge clk) begin
    if (en) begin
      pn  <= pos * nrm;
      vn  <= vel * nrm;
      nsq <= nrm * nrm;
    end
  end

endmodule

FILE: hdl/pvc_bias_div.sv
// ----------------------------------------------------------------------------
// pvc_bias_div
// Pipelined restoring divider for the Baumgarte bias, one quotient bit per
// stage, with sign restore and 32-bit saturation at the end.
// ----------------------------------------------------------------------------
module pvc_bias_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic [pvc_pkg::PROD_MAG_W-1:0]  mag,
  input  logic                            neg,
  input  logic [pvc_pkg::STEP_W-1:0]      dt,
  input  pvc_pkg::side_t                  side_in,
  output logic signed [31:0]              bias,
  output pvc_pkg::side_t                  side_out
);
  import pvc_pkg::*;

  localparam int LAST = PROD_MAG_W - 1;

  logic [STEP_W-1:0]     rem_q  [PROD_MAG_W];
  logic [PROD_MAG_W-1:0] num_q  [PROD_MAG_W];
  logic [STEP_W-1:0]     dt_q   [PROD_MAG_W];
  logic                  neg_q  [PROD_MAG_W];
  side_t                 side_q [PROD_MAG_W];

  for (genvar k = 0; k < PROD_MAG_W; k++) begin : g_stage
    logic [STEP_W-1:0]     rem_in;
    logic [PROD_MAG_W-1:0] num_in;
    logic [STEP_W-1:0]     dt_in;
    logic                  neg_in;
    side_t                 sd_in;
    logic [STEP_W:0]       trial;
    logic                  fits;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = mag;
      assign dt_in  = dt;
      assign neg_in = neg;
      assign sd_in  = side_in;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign dt_in  = dt_q[k-1];
      assign neg_in = neg_q[k-1];
      assign sd_in  = side_q[k-1];
    end

    assign trial = {rem_in, num_in[PROD_MAG_W-1]};
    assign fits  = trial >= {1'b0, dt_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= fits ? STEP_W'(trial - {1'b0, dt_in}) : trial[STEP_W-1:0];
        num_q[k]  <= {num_in[PROD_MAG_W-2:0], fits};
        dt_q[k]   <= dt_in;
        neg_q[k]  <= neg_in;
        side_q[k] <= sd_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_q[LAST]) begin
        if (num_q[LAST] > PROD_MAG_W'(64'd2147483648)) begin
          bias <= 32'sh80000000;
        end else begin
          bias <= -num_q[LAST][31:0];
        end
      end else begin
        if (num_q[LAST] > PROD_MAG_W'(64'd2147483647)) begin
          bias <= 32'sh7fffffff;
        end else begin
          bias <= num_q[LAST][31:0];
        end
      end
      side_out <= side_q[LAST];
    end
  end

endmodule

FILE: hdl/pvc_impulse_lane.sv
// ----------------------------------------------------------------------------
// pvc_impulse_lane
// One axis of the impulse: |n_i|*|s|, scaled division by n.n with a cap at
// 2^32, then the saturated velocity update, or the input velocity if degenerate.
// ----------------------------------------------------------------------------
module pvc_impulse_lane (
  input  logic                      clk,
  input  logic                      en,
  input  logic [31:0]               nrm,
  input  logic [pvc_pkg::QUO_W-1:0] smag,
  input  logic                      s_neg,
  input  logic [63:0]               nn,
  input  logic [31:0]               vel,
  input  logic                      degen_in,
  output logic [31:0]               new_vel,
  output logic                      degen_out
);
  import pvc_pkg::*;

  localparam int PROD_W = 32 + QUO_W;
  localparam int LAST = QUO_W - 1;
  localparam logic [QUO_W-1:0] QCAP = QUO_W'(1) << (QUO_W - 1);

  logic [31:0]       nmag;
  logic [PROD_W-1:0] prod_m;
  logic              neg_m, degen_m;
  logic [63:0]       nn_m;
  logic [31:0]       vel_m;

  logic [63:0]       rem_o, nn_o;
  logic [QUO_W-1:0]  low_o;
  logic              over_o, neg_o, degen_o;
  logic [31:0]       vel_o;

  logic [63:0]       rem_q   [QUO_W];
  logic [QUO_W-1:0]  low_q   [QUO_W];
  logic [63:0]       nn_q    [QUO_W];
  logic              over_q  [QUO_W];
  logic              neg_q   [QUO_W];
  logic              degen_q [QUO_W];
  logic [31:0]       vel_q   [QUO_W];

  logic [QUO_W-1:0]  qcap;
  logic signed [63:0] dv, sum;

  assign nmag = nrm[31] ? -nrm : nrm;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_m  <= nmag * smag;
      neg_m   <= nrm[31] ^ s_neg;
      nn_m    <= nn;
      vel_m   <= vel;
      degen_m <= degen_in;
    end
  end

  // Quotients of 2^33 and above are caught here; the rest fit 33 steps.
  always_ff @(posedge clk) begin
    if (en) begin
      over_o  <= (prod_m >> OVR_SHIFT) >= {1'b0, nn_m};
      rem_o   <= ((prod_m >> OVR_SHIFT) >= {1'b0, nn_m}) ? 64'd0
                                                         : 64'(prod_m >> OVR_SHIFT);
      low_o   <= QUO_W'(prod_m << FRAC_BITS);
      nn_o    <= nn_m;
      neg_o   <= neg_m;
      vel_o   <= vel_m;
      degen_o <= degen_m;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [63:0]      rem_in, nn_in;
    logic [QUO_W-1:0] low_in;
    logic             over_in, neg_in, degen_k;
    logic [31:0]      vel_in;
    logic [64:0]      trial;
    logic             fits;

    if (k == 0) begin : g_first
      assign rem_in  = rem_o;
      assign low_in  = low_o;
      assign nn_in   = nn_o;
      assign over_in = over_o;
      assign neg_in  = neg_o;
      assign degen_k = degen_o;
      assign vel_in  = vel_o;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign low_in  = low_q[k-1];
      assign nn_in   = nn_q[k-1];
      assign over_in = over_q[k-1];
      assign neg_in  = neg_q[k-1];
      assign degen_k = degen_q[k-1];
      assign vel_in  = vel_q[k-1];
    end

    assign trial = {rem_in, low_in[QUO_W-1]};
    assign fits  = trial >= {1'b0, nn_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]   <= fits ? 64'(trial - {1'b0, nn_in}) : trial[63:0];
        low_q[k]   <= {low_in[QUO_W-2:0], fits};
        nn_q[k]    <= nn_in;
        over_q[k]  <= over_in;
        neg_q[k]   <= neg_in;
        degen_q[k] <= degen_k;
        vel_q[k]   <= vel_in;
      end
    end
  end

  assign qcap = (over_q[LAST] || low_q[LAST] > QCAP) ? QCAP : low_q[LAST];
  assign dv   = neg_q[LAST] ? -$signed({31'b0, qcap}) : $signed({31'b0, qcap});
  assign sum  = $signed(vel_q[LAST]) + dv;

  always_ff @(posedge clk) begin
    if (en) begin
      new_vel   <= degen_q[LAST] ? vel_q[LAST] : sat32(sum);
      degen_out <= degen_q[LAST];
    end
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Plane velocity constraint testbench
// Drives body and plane transactions through the constraint pipeline under
// random backpressure on both sides. Each accepted transaction is predicted
// by a fixed-point impulse calculation or given inline, and each result is
// compared field by field in order. A short directed table runs first,
// then random phases run under several register settings written over APB.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pvc_pkg::*;

  typedef struct {
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [31:0] vel_x, vel_y, vel_z;
    logic signed [31:0] nrm_x, nrm_y, nrm_z;
    logic signed [31:0] offset;
    logic [31:0]        mass;
    logic [15:0]        dt;
  } body_t;

  typedef struct {
    logic signed [31:0] vx, vy, vz;
    logic               degen;
  } new_vel_t;

  typedef struct {
    body_t    body;
    bit       typed;
    new_vel_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
  logic signed [31:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic signed [31:0] plane_offset = '0;
  logic [31:0] body_mass = '0;
  logic [15:0] delta_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] new_vel_x, new_vel_y, new_vel_z;
  logic degenerate;

  // Register shadow used by the impulse calculation.
  logic [GAIN_W-1:0] gain_q = GAIN_RESET;
  logic [STEP_W-1:0] min_step_q = MIN_STEP_RESET;
  logic [STEP_W-1:0] fallback_q = FALLBACK_RESET;

  new_vel_t expected_vel_q[$];
  int errors = 0;
  int results_seen = 0;
  int degen_seen = 0;
  int items_sent = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  plane_velocity_constraint_top u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .plane_offset(plane_offset), .body_mass(body_mass), .delta_time(delta_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .new_vel_x(new_vel_x), .new_vel_y(new_vel_y), .new_vel_z(new_vel_z),
    .degenerate(degenerate)
  );

  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (x < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic new_vel_t solve_impulse(body_t b);
    longint p[3], v[3], n[3];
    longint c, jv, bias, s, step, prod, dv;
    logic [63:0] nn, smag, nmag;
    logic [127:0] quo;
    new_vel_t r;
    longint nv[3];
    p[0] = b.pos_x; p[1] = b.pos_y; p[2] = b.pos_z;
    v[0] = b.vel_x; v[1] = b.vel_y; v[2] = b.vel_z;
    n[0] = b.nrm_x; n[1] = b.nrm_y; n[2] = b.nrm_z;
    nn = 0;
    for (int i = 0; i < 3; i++) nn += 64'(n[i] * n[i]);
    r.vx = b.vel_x; r.vy = b.vel_y; r.vz = b.vel_z;
    r.degen = 1'b1;
    if (b.mass == 0 || nn == 0) return r;
    step = b.dt;
    if (b.dt < min_step_q || b.dt == 0) step = fallback_q;
    if (step == 0) step = 1;
    // Each product is floored to the fraction width before summing.
    c = clamp32(((n[0] * p[0]) >>> FRAC_BITS) + ((n[1] * p[1]) >>> FRAC_BITS)
                + ((n[2] * p[2]) >>> FRAC_BITS) - longint'(b.offset));
    jv = clamp32(((n[0] * v[0]) >>> FRAC_BITS) + ((n[1] * v[1]) >>> FRAC_BITS)
                 + ((n[2] * v[2]) >>> FRAC_BITS));
    prod = longint'(gain_q) * c;
    bias = clamp32(prod / step);
    s = -jv - bias;
    smag = (s < 0) ? 64'(-s) : 64'(s);
    for (int i = 0; i < 3; i++) begin
      nmag = (n[i] < 0) ? 64'(-n[i]) : 64'(n[i]);
      quo = (128'(nmag * smag) << FRAC_BITS) / 128'(nn);
      if (quo > 128'h1_0000_0000) quo = 128'h1_0000_0000;
      dv = ((n[i] < 0) != (s < 0)) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
      nv[i] = clamp32(v[i] + dv);
    end
    r.vx = nv[0][31:0]; r.vy = nv[1][31:0]; r.vz = nv[2][31:0];
    r.degen = 1'b0;
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00}); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_GAIN:     gain_q = value[GAIN_W-1:0];
      REG_MIN_STEP: min_step_q = value[STEP_W-1:0];
      REG_FALLBACK: fallback_q = value[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] g, logic [31:0] ms, logic [31:0] fb);
    write_reg(REG_GAIN, g);
    write_reg(REG_MIN_STEP, ms);
    write_reg(REG_FALLBACK, fb);
  endtask

  // Drives one transaction, holding it until accepted, then records its result.
  task automatic send_body(body_t b, bit typed, new_vel_t want);
    while (!no_idle && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= b.pos_x; pos_y <= b.pos_y; pos_z <= b.pos_z;
    vel_x <= b.vel_x; vel_y <= b.vel_y; vel_z <= b.vel_z;
    normal_x <= b.nrm_x; normal_y <= b.nrm_y; normal_z <= b.nrm_z;
    plane_offset <= b.offset; body_mass <= b.mass; delta_time <= b.dt;
    do @(posedge clk); while (!in_ready);
    expected_vel_q.push_back(typed ? want : solve_impulse(b));
    items_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_vel_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] moderate();
    return 32'(int'($urandom_range(0, 2097152)) - 1048576);
  endfunction

  function automatic body_t random_body();
    body_t b;
    int kind;
    kind = $urandom_range(0, 9);
    b.pos_x = moderate(); b.pos_y = moderate(); b.pos_z = moderate();
    b.vel_x = moderate(); b.vel_y = moderate(); b.vel_z = moderate();
    b.nrm_x = moderate(); b.nrm_y = moderate(); b.nrm_z = moderate();
    b.offset = moderate();
    b.mass = $urandom_range(1, 32'hFFFF_FFFF);
    b.dt = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    case (kind)
      0: begin
        b.pos_x = $urandom; b.pos_y = $urandom; b.pos_z = $urandom;
        b.vel_x = $urandom; b.vel_y = $urandom; b.vel_z = $urandom;
        b.nrm_x = $urandom; b.nrm_y = $urandom; b.nrm_z = $urandom;
        b.offset = $urandom; b.mass = $urandom;
      end
      1: b.mass = 0;
      2: begin
        b.nrm_x = 0; b.nrm_y = 0; b.nrm_z = 0;
      end
      3, 4: begin
        // Straight line y = slope*x + intercept.
        b.nrm_x = -moderate(); b.nrm_y = 32'h0001_0000; b.nrm_z = 0;
      end
      default: ;
    endcase
    return b;
  endfunction

  function automatic stim_row_t row(logic [31:0] px, logic [31:0] vx, logic [31:0] vy,
                                    logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                                    logic [31:0] d, logic [31:0] m, logic [15:0] dt,
                                    bit typed);
    stim_row_t r;
    r.body.pos_x = px; r.body.pos_y = px; r.body.pos_z = px;
    r.body.vel_x = vx; r.body.vel_y = vy; r.body.vel_z = vx;
    r.body.nrm_x = nx; r.body.nrm_y = ny; r.body.nrm_z = nz;
    r.body.offset = d; r.body.mass = m; r.body.dt = dt;
    r.typed = typed;
    r.want.vx = vx; r.want.vy = vy; r.want.vz = vx; r.want.degen = 1'b1;
    return r;
  endfunction

  // Receiver: random stalls, a no-stall stretch, and one long hold-off.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= no_idle || ($urandom_range(0, 99) >= 29);
    end
  end

  always @(posedge clk) begin
    new_vel_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (degenerate) degen_seen++;
      if (expected_vel_q.size() == 0) begin
        $display("%0t: unexpected result vel=(%0d,%0d,%0d) degenerate=%0b",
                 $time, new_vel_x, new_vel_y, new_vel_z, degenerate);
        errors++;
      end else begin
        want = expected_vel_q.pop_front();
        if (new_vel_x !== want.vx) begin
          $display("%0t: new_vel_x expected %0d actual %0d", $time, want.vx, new_vel_x);
          errors++;
        end
        if (new_vel_y !== want.vy) begin
          $display("%0t: new_vel_y expected %0d actual %0d", $time, want.vy, new_vel_y);
          errors++;
        end
        if (new_vel_z !== want.vz) begin
          $display("%0t: new_vel_z expected %0d actual %0d", $time, want.vz, new_vel_z);
          errors++;
        end
        if (degenerate !== want.degen) begin
          $display("%0t: degenerate expected %0b actual %0b", $time, want.degen,
                   degenerate);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t table_rows[$];
    new_vel_t unused;
    logic [31:0] cfg_gain[5], cfg_min[5], cfg_fb[5];
    unused = '{default: '0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: degenerate cases carry their result inline.
    table_rows.push_back(row(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h0001_0000, 0, 0, 0, 0, 16'd1092, 1));
    table_rows.push_back(row(32'h8000_0000, 32'h1234_5678, 32'hFFFF_FFFF,
                             0, 0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1));
    table_rows.push_back(row(0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 1));
    table_rows.push_back(row(32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000,
                             32'h0000_8000, 32'h0001_0000, 0, 32'h0000_4000,
                             32'h0001_0000, 16'd1092, 0));
    table_rows.push_back(row(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0,
                             0, 32'h0001_0000, 16'd0, 0));
    table_rows.push_back(row(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0,
                             0, 32'h0001_0000, 16'hFFFF, 0));
    table_rows.push_back(row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'hFFFF_FFFF, 16'd1, 0));
    table_rows.push_back(row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'd1, 16'd1, 0));
    table_rows.push_back(row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h0000_0001, 0, 0, 32'h7FFF_FFFF, 32'd1, 16'd0, 0));
    table_rows.push_back(row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
                             32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                             32'h0000_0001, 32'd1, 16'd2, 0));
    table_rows.push_back(row(32'h0010_0000, 32'hFFF0_0000, 32'h0008_0000,
                             32'hFFFE_0000, 32'h0001_0000, 0, 32'h0003_0000,
                             32'h0005_0000, 16'd1092, 0));
    foreach (table_rows[i]) send_body(table_rows[i].body, table_rows[i].typed,
                                      table_rows[i].want);
    drain();

    // Extremes first, then a shallow line-fit gain, a random setting, and a zero fallback.
    cfg_gain = '{0, 32'hF_FFFF, 9830, 32'($urandom_range(0, 32'hF_FFFF)), 32'hF_FFFF};
    cfg_min = '{0, 32'hFFFF, 1, 32'($urandom_range(0, 32'hFFFF)), 0};
    cfg_fb = '{1, 32'hFFFF, 1092, 32'($urandom_range(1, 32'hFFFF)), 0};
    for (int ph = 0; ph < 5; ph++) begin
      set_regs(cfg_gain[ph], cfg_min[ph], cfg_fb[ph]);
      // The zero-fallback setting also sees a zero step directly.
      if (ph == 4) begin
        table_rows[4].body.dt = 0;
        send_body(table_rows[4].body, 1'b0, unused);
      end
      for (int k = 0; k < 210; k++) begin
        if (ph == 2 && k == 20) hold_req = 1'b1;
        no_idle = (ph == 3 && k >= 50 && k < 150);
        send_body(random_body(), 1'b0, unused);
      end
      no_idle = 1'b0;
      drain();
    end

    repeat (PIPE_LAT + 20) @(posedge clk);
    $display("Sent %0d transactions over six register settings, incl. a long output hold.",
             items_sent);
    $display("Checked %0d results, %0d of them degenerate.", results_seen, degen_seen);
    if (errors == 0 && expected_vel_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
